>>> hdl/bf3_pkg.sv
// ----------------------------------------------------------------------------
// bf3_pkg
// Shared types and constants of the 3x3 box filter: geometry limits,
// register indexes, request payloads and the control bundles between stages.
// ----------------------------------------------------------------------------
package bf3_pkg;

    // geometry limits
    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int WIN         = 3;
    localparam int DIM_W       = 13;
    localparam int POS_W       = 12;
    localparam int PIX_W       = 8;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [DIM_W-1:0] DIM_MIN        = DIM_W'(WIN);
    localparam logic [DIM_W-1:0] DIM_MAX_WIDTH  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] DIM_MAX_HEIGHT = DIM_W'(MAX_HEIGHT);
    localparam logic [DIM_W-1:0] RESET_WIDTH    = 13'd640;
    localparam logic [DIM_W-1:0] RESET_HEIGHT   = 13'd480;

    // window sum / 9 as multiply by ceil(2^16 / 9), exact for sums up to 2295
    localparam int SUM_W      = 12;
    localparam int DIV9_SHIFT = 16;
    localparam logic [13:0] DIV9_MULT = 14'd7282;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_index;

    // input request
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } t_in_item;

    // result request
    typedef struct packed {
        logic [PIX_W-1:0] out_pixel;
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_column;
        logic             last_of_run;
    } t_out_item;

    // position of the pixel in the window stage
    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] column;
        logic             last_row;
        logic             last_col;
    } t_pos_info;

    // column read from the two line stores: rows r-2 and r-1
    typedef struct packed {
        logic [PIX_W-1:0] upper;
        logic [PIX_W-1:0] lower;
    } t_line_col;

endpackage

>>> hdl/bf3_line_store.sv
// ----------------------------------------------------------------------------
// bf3_line_store
// Two line memories holding the rows above the current one. One registered
// read per accepted pixel, one write when that pixel leaves the window stage.
// ----------------------------------------------------------------------------
module bf3_line_store (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [bf3_pkg::ADDR_W-1:0]   i_rd_addr,
    input  logic                         i_wr_en,
    input  logic [bf3_pkg::ADDR_W-1:0]   i_wr_addr,
    input  logic [bf3_pkg::PIX_W-1:0]    i_wr_pixel,
    output bf3_pkg::t_line_col           o_col
);
    import bf3_pkg::*;

    logic [PIX_W-1:0] r_upper_mem [MAX_WIDTH];
    logic [PIX_W-1:0] r_lower_mem [MAX_WIDTH];
    t_line_col        r_col;
    logic             bypass;

    // same column read while it is being written (restart at column zero)
    assign bypass = i_wr_en && (i_rd_addr == i_wr_addr);

    // row r-1 moves up, the new pixel becomes row r-1
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_upper_mem[i_wr_addr] <= r_col.lower;
            r_lower_mem[i_wr_addr] <= i_wr_pixel;
        end
    end

    // registered read with write forwarding
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (bypass) begin
                r_col.upper <= r_col.lower;
                r_col.lower <= i_wr_pixel;
            end else begin
                r_col.upper <= r_upper_mem[i_rd_addr];
                r_col.lower <= r_lower_mem[i_rd_addr];
            end
        end
    end

    assign o_col = r_col;

endmodule

>>> hdl/bf3_window.sv
// ----------------------------------------------------------------------------
// bf3_window
// 3x3 window registers, window mean and the list of results that one pixel
// releases, packed in raster order with the last one marked.
// ----------------------------------------------------------------------------
module bf3_window (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_move,
    input  logic [bf3_pkg::PIX_W-1:0]    i_pixel,
    input  bf3_pkg::t_pos_info           i_pos,
    input  bf3_pkg::t_line_col           i_col,
    output bf3_pkg::t_out_item           o_res [bf3_pkg::MAX_RESULTS],
    output logic [bf3_pkg::CNT_W-1:0]    o_cnt
);
    import bf3_pkg::*;

    // two newest columns, index 0 is row r-2
    logic [PIX_W-1:0] r_prev [WIN];
    logic [PIX_W-1:0] r_cur  [WIN];
    logic [PIX_W-1:0] right  [WIN];

    logic [SUM_W-1:0]            sum;
    logic [SUM_W+13:0]           prod;
    logic [PIX_W-1:0]            mean;
    logic                        row_ge1, row_ge2, col_ge1, col_ge2;
    logic [MAX_RESULTS-1:0]      hit;
    t_out_item                   cand [MAX_RESULTS];
    t_out_item                   res  [MAX_RESULTS];
    logic [CNT_W-1:0]            n;

    assign right[0] = i_col.upper;
    assign right[1] = i_col.lower;
    assign right[2] = i_pixel;

    // window shift on every pixel that leaves this stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN; i++) begin
                r_prev[i] <= '0;
                r_cur[i]  <= '0;
            end
        end else if (i_move) begin
            for (int i = 0; i < WIN; i++) begin
                r_prev[i] <= r_cur[i];
                r_cur[i]  <= right[i];
            end
        end
    end

    // sum of nine and divide by nine
    always_comb begin
        sum = '0;
        for (int i = 0; i < WIN; i++) begin
            sum = sum + SUM_W'(r_prev[i]) + SUM_W'(r_cur[i]) + SUM_W'(right[i]);
        end
    end

    assign prod = (SUM_W+14)'(sum) * (SUM_W+14)'(DIV9_MULT);
    assign mean = prod[DIV9_SHIFT +: PIX_W];

    assign row_ge1 = (i_pos.row != '0);
    assign row_ge2 = (i_pos.row[POS_W-1:1] != '0);
    assign col_ge1 = (i_pos.column != '0);
    assign col_ge2 = (i_pos.column[POS_W-1:1] != '0);

    // candidate results in raster order
    always_comb begin
        hit[0] = row_ge1 && col_ge1;
        hit[1] = row_ge1 && i_pos.last_col;
        hit[2] = i_pos.last_row && col_ge1;
        hit[3] = i_pos.last_row && i_pos.last_col;

        cand[0].out_pixel  = (row_ge2 && col_ge2) ? mean : r_cur[1];
        cand[0].out_row    = i_pos.row - 1'b1;
        cand[0].out_column = i_pos.column - 1'b1;
        cand[1].out_pixel  = right[1];
        cand[1].out_row    = i_pos.row - 1'b1;
        cand[1].out_column = i_pos.column;
        cand[2].out_pixel  = r_cur[2];
        cand[2].out_row    = i_pos.row;
        cand[2].out_column = i_pos.column - 1'b1;
        cand[3].out_pixel  = i_pixel;
        cand[3].out_row    = i_pos.row;
        cand[3].out_column = i_pos.column;

        // last one taken is the one with no later hit
        for (int k = 0; k < MAX_RESULTS; k++) begin
            cand[k].last_of_run = hit[k] && ((hit >> (k + 1)) == '0);
        end
    end

    // pack the hits to the front
    always_comb begin
        n = '0;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            res[k] = '0;
        end
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (hit[k]) begin
                res[n[CNT_W-2:0]] = cand[k];
                n = n + 1'b1;
            end
        end
    end

    assign o_res = res;
    assign o_cnt = n;

endmodule

>>> hdl/bf3_out_queue.sv
// ----------------------------------------------------------------------------
// bf3_out_queue
// Result register for the results of one pixel; hands them out one per
// request and signals when the next set can be loaded.
// ----------------------------------------------------------------------------
module bf3_out_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  bf3_pkg::t_out_item           i_res [bf3_pkg::MAX_RESULTS],
    input  logic [bf3_pkg::CNT_W-1:0]    i_cnt,
    output logic                         o_room,
    output logic                         o_valid,
    output bf3_pkg::t_out_item           o_data,
    input  logic                         i_stall
);
    import bf3_pkg::*;

    t_out_item        r_res [MAX_RESULTS];
    logic [CNT_W-1:0] r_cnt;
    logic             take;

    assign take    = (r_cnt != '0) && !i_stall;
    assign o_room  = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && take);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_res[0];

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_cnt;
        end else if (take) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // result slots, shifted toward the head on each request
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end else if (take) begin
            for (int k = 0; k < MAX_RESULTS - 1; k++) begin
                r_res[k] <= r_res[k + 1];
            end
        end
    end

    // never more results held than one pixel can release
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_RESULTS))
        else $error("result count out of range");

    // a new set only replaces results that are gone
    a_load_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_room)
        else $error("results loaded over pending results");

    // last pending result taken with nothing loaded leaves the queue empty
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && (r_cnt == CNT_W'(1)) && !i_load) |=> !o_valid)
        else $error("queue not empty after draining");

    // the last pending result carries the run-end mark
    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_cnt == CNT_W'(1))) |-> o_data.last_of_run)
        else $error("final result of a run not marked");

endmodule

>>> hdl/box_filter_3x3.sv
// ----------------------------------------------------------------------------
// box_filter_3x3
// Streaming 3x3 mean filter over 8-bit grayscale pixels with border passthrough.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one per clock unless the input stalls. Each
// pixel releases from zero to four results (filtered pixel one row and one
// column behind, plus border flushes in the last column and last row); the
// result register hands out one result per clock while the output is not
// stalled, so a pixel with more than one result holds the input stall until
// all but the last are handed out. A pixel's first result is valid once the
// result register has room and loads it: the line store read is registered
// with the pixel when it is accepted, and the window sum and divide settle
// before the result register loads. The two line stores are 4096 x 8
// memories with one read and one write port each; they need no clearing pass
// after reset. Geometry registers saturate to 3..4096 and are written through
// a port that is always ready.
module box_filter_3x3 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // pixel input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bf3_pkg::t_in_item             i_in_data,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bf3_pkg::t_out_item            o_out_data,
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  bf3_pkg::t_cfg_index           i_cfg_index,
    input  logic [bf3_pkg::DIM_W-1:0]     i_cfg_data
);
    import bf3_pkg::*;

    logic [DIM_W-1:0] r_width, r_height;
    logic [DIM_W-1:0] cfg_clamped_w, cfg_clamped_h;
    logic [POS_W-1:0] r_row, r_col;
    logic [POS_W-1:0] n_row, n_col;

    logic             in_accept, s1_move, q_room;
    logic [POS_W-1:0] col_a, row_a, col_b, row_c;
    logic [DIM_W-1:0] row_b;
    logic             wrap;
    t_pos_info        pos;

    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_pixel;
    t_pos_info        r_s1_pos;

    t_line_col        line_col;
    t_out_item        win_res [MAX_RESULTS];
    logic [CNT_W-1:0] win_cnt;

    assign o_cfg_ready = 1'b1;

    // saturate geometry on write
    always_comb begin
        if (i_cfg_data < DIM_MIN) begin
            cfg_clamped_w = DIM_MIN;
            cfg_clamped_h = DIM_MIN;
        end else begin
            cfg_clamped_w = (i_cfg_data > DIM_MAX_WIDTH)  ? DIM_MAX_WIDTH  : i_cfg_data;
            cfg_clamped_h = (i_cfg_data > DIM_MAX_HEIGHT) ? DIM_MAX_HEIGHT : i_cfg_data;
        end
    end

    // geometry registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_width  <= cfg_clamped_w;
                CFG_IMAGE_HEIGHT: r_height <= cfg_clamped_h;
                default: ;
            endcase
        end
    end

    // handshake: the window stage moves when the result register frees up
    assign s1_move    = r_s1_valid && q_room;
    assign o_in_stall = r_s1_valid && !q_room;
    assign in_accept  = i_in_valid && !o_in_stall;

    // position of the incoming pixel
    always_comb begin
        col_a = i_in_data.frame_start ? '0 : r_col;
        row_a = i_in_data.frame_start ? '0 : r_row;
        wrap  = ({1'b0, col_a} >= r_width);
        col_b = wrap ? '0 : col_a;
        row_b = wrap ? ({1'b0, row_a} + 1'b1) : {1'b0, row_a};
        row_c = (row_b >= r_height) ? '0 : row_b[POS_W-1:0];

        pos.row      = row_c;
        pos.column   = col_b;
        pos.last_col = ({1'b0, col_b} == (r_width - 1'b1));
        pos.last_row = ({1'b0, row_c} == (r_height - 1'b1));

        n_col = pos.last_col ? '0 : col_b + 1'b1;
        if (pos.last_col) begin
            n_row = pos.last_row ? '0 : row_c + 1'b1;
        end else begin
            n_row = row_c;
        end
    end

    // position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (in_accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // input register of the window stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_pixel <= i_in_data.pixel;
            r_s1_pos   <= pos;
        end
    end

    bf3_line_store u_line_store (
        .i_clk      (i_clk),
        .i_rd_en    (in_accept),
        .i_rd_addr  (col_b[ADDR_W-1:0]),
        .i_wr_en    (s1_move),
        .i_wr_addr  (r_s1_pos.column[ADDR_W-1:0]),
        .i_wr_pixel (r_s1_pixel),
        .o_col      (line_col)
    );

    bf3_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_move  (s1_move),
        .i_pixel (r_s1_pixel),
        .i_pos   (r_s1_pos),
        .i_col   (line_col),
        .o_res   (win_res),
        .o_cnt   (win_cnt)
    );

    bf3_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s1_move),
        .i_res   (win_res),
        .i_cnt   (win_cnt),
        .o_room  (q_room),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

    // an accepted pixel always lands inside the frame
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |-> (({1'b0, pos.column} < r_width) && ({1'b0, pos.row} < r_height)))
        else $error("position outside the frame");

    // input only held back by a pixel waiting in the window stage
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && o_out_valid))
        else $error("input stalled with nothing pending");

endmodule
